FILE: hdl/tpd_pkg.sv
`timescale 1ns / 1ps

package tpd_pkg;

	// Sizes
	localparam int TAG_COUNT  = 60;
	localparam int ROM_SIZE   = 60;
	localparam int PATH_DEPTH = 32;
	localparam int TAG_LIMIT  = (TAG_COUNT < ROM_SIZE) ? TAG_COUNT : ROM_SIZE;
	localparam int TAG_W      = 40;
	localparam int BYTE_W     = 8;
	localparam int NODE_W     = 6;
	localparam int CNT_W      = 6;
	localparam int ROM_AW     = $clog2(ROM_SIZE);
	localparam int PATH_AW    = $clog2(PATH_DEPTH);

	// Direction letters
	localparam logic [BYTE_W-1:0] DIR_N = 8'h4E;
	localparam logic [BYTE_W-1:0] DIR_S = 8'h53;
	localparam logic [BYTE_W-1:0] DIR_W = 8'h57;
	localparam logic [BYTE_W-1:0] DIR_E = 8'h45;
	localparam logic [BYTE_W-1:0] DIR_G = 8'h47;

	// Headings
	localparam logic [1:0] HEAD_N = 2'd0;
	localparam logic [1:0] HEAD_S = 2'd1;
	localparam logic [1:0] HEAD_W = 2'd2;
	localparam logic [1:0] HEAD_E = 2'd3;

	// Actions
	localparam logic [2:0] ACT_FOLLOW  = 3'd0;
	localparam logic [2:0] ACT_RIGHT   = 3'd1;
	localparam logic [2:0] ACT_LEFT    = 3'd2;
	localparam logic [2:0] ACT_REVERSE = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;
	localparam logic [2:0] ACT_NONE    = 3'd5;

	// Item commands
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TAG  = 1'b1;

	// Known tag identifiers; the entry index is the node number
	localparam logic [TAG_W-1:0] TAG_ROM [ROM_SIZE] = '{
		40'h992E09F04E, 40'h695C12EFC8, 40'h494509F0F5, 40'h89640CF011, 40'h895412EF20,
		40'h996112EF05, 40'hB95712EF13, 40'hA95512EF01, 40'hA95612EF02, 40'h790E0BF08C,
		40'h695B12EFCF, 40'h594309F0E3, 40'hF97B0AF078, 40'h896F0AF01C, 40'h896B0AF018,
		40'h69E309F073, 40'h69DF09F04F, 40'hE9CC09F0DC, 40'hE9C809F0D8, 40'h494709F0F7,
		40'h694109F0D1, 40'h293209F0E2, 40'h591A07F0B4, 40'h891707F069, 40'hF91407F01A,
		40'h499A06F025, 40'h799406F01B, 40'h099906F066, 40'hC99706F0A8, 40'h499606F029,
		40'h399206F05D, 40'h599306F03C, 40'hB91B06F054, 40'hA91B07F045, 40'h899506F0EA,
		40'h499206F02D, 40'hB99606F0D9, 40'h199906F076, 40'hC91307F02D, 40'h491607F0A8,
		40'h991707F079, 40'h091907F0E7, 40'hB91B07F055, 40'h099907F067, 40'h199F07F071,
		40'hE99B07F085, 40'h19A207F04C, 40'hA91A08F04B, 40'h991E08F07F, 40'hA92E09F07E,
		40'h093008F0C1, 40'h092C08F0DD, 40'h296212EFB6, 40'hA9AD08F0FC, 40'hA9B108F0E0,
		40'h19C008F021, 40'h19C408F025, 40'hC96112EF55, 40'h496912EFDD, 40'hF99807F096
	};

	typedef struct packed {
		logic                cmd;
		logic [4:0]          path_index;
		logic [BYTE_W-1:0]   path_byte;
		logic [CNT_W-1:0]    path_length;
		logic                load_last;
		logic [TAG_W-1:0]    tag_id;
	} in_item_t;

	typedef struct packed {
		logic [2:0]          action;
		logic [NODE_W-1:0]   node;
		logic [1:0]          heading;
		logic                path_done;
		logic                unknown_tag;
		logic                load_taken;
	} out_item_t;

	// Bit 2 flags a direction letter, bits 1:0 give its heading
	function automatic logic [2:0] dir_decode(input logic [BYTE_W-1:0] b);
		logic [2:0] r;
		unique case (b)
			DIR_N:   r = {1'b1, HEAD_N};
			DIR_S:   r = {1'b1, HEAD_S};
			DIR_W:   r = {1'b1, HEAD_W};
			DIR_E:   r = {1'b1, HEAD_E};
			default: r = {1'b0, HEAD_N};
		endcase
		return r;
	endfunction

	// Action for a new direction against the old heading
	function automatic logic [2:0] turn_action(input logic [1:0] dir, input logic [1:0] old);
		logic [2:0] a;
		if (dir == old) begin
			a = ACT_FOLLOW;
		end else begin
			unique case ({dir, old})
				{HEAD_N, HEAD_S}, {HEAD_S, HEAD_N},
				{HEAD_W, HEAD_E}, {HEAD_E, HEAD_W}: a = ACT_REVERSE;
				{HEAD_N, HEAD_W}, {HEAD_S, HEAD_E},
				{HEAD_W, HEAD_S}, {HEAD_E, HEAD_N}: a = ACT_RIGHT;
				default:                            a = ACT_LEFT;
			endcase
		end
		return a;
	endfunction

endpackage

FILE: hdl/tpd_path_mem.sv
`timescale 1ns / 1ps

module tpd_path_mem
	import tpd_pkg::*;
(
	input  logic               clk,
	input  logic               we,
	input  logic [PATH_AW-1:0] waddr,
	input  logic [BYTE_W-1:0]  wdata,
	input  logic [PATH_AW-1:0] raddr,
	output logic [BYTE_W-1:0]  rdata
);

	logic [BYTE_W-1:0] mem [PATH_DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/tag_path_heading_decider.sv
`timescale 1ns / 1ps

// Heading decider for a line-following vehicle.
// Input channel: an item is taken at a rising edge with start high and busy low.
//   cmd = load: one path byte is written (only while the previous path is done);
//   the item with load_last sets the path length and opens the new path.
//   cmd = tag: the 40-bit tag is looked up, the node located in the path, and
//   the following direction byte turned into an action and a new heading.
// Output channel: done is high for one cycle with the result; there is no
// back-pressure, the receiver must take it in that cycle.
// A load item's result is registered and given in the cycle after acceptance; it
// leaves busy low, so loads can stream one per cycle.
// A tag item keeps busy high and gives done in the cycle after its last busy cycle;
// the ROM is walked up to the matching entry (all 60 tried for an unknown tag),
// then the path store over at most path length - 4 positions. One 40-bit compare
// unit walks the ROM and then the path store, one compare per cycle for the
// ROM; each path position takes an address step and then a compare step, as the
// path store read is registered.
// Reset: path done, heading north, node 0, path length 0; the path store is
// not cleared.

module tag_path_heading_decider
	import tpd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_item_t  item,
	output logic      done,
	output out_item_t result
);

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_ROM   = 6'b000010,
		S_PADDR = 6'b000100,
		S_PCMP  = 6'b001000,
		S_DADDR = 6'b010000,
		S_DDEC  = 6'b100000
	} state_t;

	localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(TAG_LIMIT - 1);

	state_t            state_q;
	logic              done_q;
	logic [CNT_W-1:0]  path_count_q;
	logic              path_done_q;
	logic [1:0]        heading_q;
	logic [NODE_W-1:0] node_q;
	logic [ROM_AW-1:0] rom_idx_q;
	logic [CNT_W-1:0]  scan_q;
	logic [CNT_W-1:0]  pos_q;
	logic              unknown_q;
	logic [TAG_W-1:0]  tag_q;
	out_item_t         result_q;

	logic              accept;
	logic              load_we;
	logic [CNT_W-1:0]  len_sat;
	logic [PATH_AW-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic [TAG_W-1:0]  cmp_a;
	logic [TAG_W-1:0]  cmp_b;
	logic              cmp_eq;
	logic              short_path;
	logic              scan_end;
	logic [2:0]        dir_info;
	logic              is_goal;
	logic [2:0]        dec_action;
	logic [1:0]        dec_heading;
	logic              dec_done;

	// Handshake and load write
	assign busy    = (state_q != S_IDLE);
	assign accept  = start && !busy;
	assign load_we = accept && (item.cmd == CMD_LOAD) && path_done_q
		&& (32'(item.path_index) < PATH_DEPTH);
	assign len_sat = (32'(item.path_length) > PATH_DEPTH) ? CNT_W'(PATH_DEPTH)
		: item.path_length;

	// Path store
	assign rd_addr = (state_q == S_DADDR) ? PATH_AW'(pos_q + CNT_W'(1)) : PATH_AW'(scan_q);

	tpd_path_mem u_mem (
		.clk   (clk),
		.we    (load_we),
		.waddr (PATH_AW'(item.path_index)),
		.wdata (item.path_byte),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// Shared compare unit: tag against ROM entry, or path byte against node
	always_comb begin
		if (state_q == S_ROM) begin
			cmp_a = tag_q;
			cmp_b = TAG_ROM[rom_idx_q];
		end else begin
			cmp_a = TAG_W'(rd_data);
			cmp_b = TAG_W'(node_q);
		end
	end
	assign cmp_eq = (cmp_a == cmp_b);

	// Scan bounds: positions 2 .. length-3
	assign short_path = (path_count_q < CNT_W'(5));
	assign scan_end   = ({1'b0, scan_q} + (CNT_W+1)'(3)) >= {1'b0, path_count_q};

	// Direction decode
	assign dir_info    = dir_decode(rd_data);
	assign is_goal     = (rd_data == DIR_G);
	assign dec_action  = dir_info[2] ? turn_action(dir_info[1:0], heading_q)
		: (is_goal ? ACT_STOP : ACT_FOLLOW);
	assign dec_heading = dir_info[2] ? dir_info[1:0] : heading_q;
	assign dec_done    = is_goal ? 1'b1 : path_done_q;

	// Sequencer and kept state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			path_count_q <= '0;
			path_done_q  <= 1'b1;
			heading_q    <= HEAD_N;
			node_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (item.cmd == CMD_TAG) begin
							state_q <= S_ROM;
						end else begin
							done_q <= 1'b1;
							if (load_we && item.load_last) begin
								path_count_q <= len_sat;
								path_done_q  <= 1'b0;
							end
						end
					end
				end
				S_ROM: begin
					if (cmp_eq) begin
						node_q <= NODE_W'(rom_idx_q);
					end
					if (cmp_eq || rom_idx_q == ROM_LAST) begin
						state_q <= short_path ? S_DADDR : S_PADDR;
					end
				end
				S_PADDR: state_q <= S_PCMP;
				S_PCMP: begin
					if (cmp_eq || scan_end) begin
						state_q <= S_DADDR;
					end else begin
						state_q <= S_PADDR;
					end
				end
				S_DADDR: state_q <= S_DDEC;
				S_DDEC: begin
					heading_q   <= dec_heading;
					path_done_q <= dec_done;
					done_q      <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					tag_q     <= item.tag_id;
					rom_idx_q <= '0;
					unknown_q <= 1'b0;
					result_q  <= '{
						action:      ACT_NONE,
						node:        node_q,
						heading:     heading_q,
						path_done:   (load_we && item.load_last) ? 1'b0 : path_done_q,
						unknown_tag: 1'b0,
						load_taken:  load_we
					};
				end
			end
			S_ROM: begin
				rom_idx_q <= rom_idx_q + ROM_AW'(1);
				if (!cmp_eq && rom_idx_q == ROM_LAST) begin
					unknown_q <= 1'b1;
				end
				if (cmp_eq || rom_idx_q == ROM_LAST) begin
					scan_q <= CNT_W'(2);
					pos_q  <= '0;
				end
			end
			S_PCMP: begin
				if (cmp_eq) begin
					pos_q <= scan_q;
				end
				scan_q <= scan_q + CNT_W'(1);
			end
			S_DDEC: begin
				result_q <= '{
					action:      dec_action,
					node:        node_q,
					heading:     dec_heading,
					path_done:   dec_done,
					unknown_tag: unknown_q,
					load_taken:  1'b0
				};
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	// A tag item keeps the block busy and cannot finish in the next cycle
	a_tag_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.cmd == CMD_TAG) |=> (busy && !done))
		else $error("tag item did not occupy the sequencer");

	// Loads report no action and no unknown tag
	a_load_none: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.load_taken) |-> (result.action == ACT_NONE && !result.unknown_tag))
		else $error("load result carries tag fields");

	// Stop always closes the path
	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.action == ACT_STOP) |-> result.path_done)
		else $error("stop without path complete");

	// A load is only written while the previous path is complete
	a_load_gate: assert property (@(posedge clk) disable iff (!arst_n)
		load_we |-> (path_done_q && state_q == S_IDLE))
		else $error("path store written while path open");

	// The sequencer leaves the decode step with a result every time
	a_dec_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DDEC) |=> (done && !busy))
		else $error("decode step gave no result");

endmodule
